// ----- design/aabb_grid_cell_binning_top_assert.svh -----
// assertion macros shared by the binning block
`ifndef AABB_GRID_CELL_BINNING_TOP_ASSERT_SVH
`define AABB_GRID_CELL_BINNING_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define AGCB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("agcb assertion failed");

// next-cycle implication, checked out of reset
`define AGCB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("agcb assertion failed");

`endif

// ----- design/agcb_pkg.sv -----
`default_nettype none

package agcb_pkg;

    // most cells on one axis, and counter width for it
    localparam int AXIS_CELLS_MAX = 4;
    localparam int AXW = 2;

    // axis slots
    localparam int AXIS_X = 0;
    localparam int AXIS_Y = 1;
    localparam int AXIS_Z = 2;

    // configuration register indexes
    localparam logic [2:0] REG_GRID_MIN_X  = 3'd0;
    localparam logic [2:0] REG_GRID_MIN_Y  = 3'd1;
    localparam logic [2:0] REG_GRID_MIN_Z  = 3'd2;
    localparam logic [2:0] REG_CELL_SIZE_X = 3'd3;
    localparam logic [2:0] REG_CELL_SIZE_Y = 3'd4;
    localparam logic [2:0] REG_CELL_SIZE_Z = 3'd5;

    localparam logic signed [31:0] GRID_MIN_RESET  = 32'sd0;
    localparam logic [30:0]        CELL_SIZE_RESET = 31'd65536;

    // one classified instance, waiting for the cell walk
    typedef struct packed {
        logic [7:0]                  object_id;
        logic [15:0]                 instance_id;
        logic [AXIS_CELLS_MAX-1:0]   mask_x;
        logic [AXIS_CELLS_MAX-1:0]   mask_y;
        logic [AXIS_CELLS_MAX-1:0]   mask_z;
    } bin_job_t;

    // signed 32-bit add clamped to the 32-bit range
    function automatic logic signed [31:0] sat_add32(input logic signed [31:0] a,
                                                      input logic signed [31:0] b);
        logic signed [32:0] s;
        s = 33'(a) + 33'(b);
        if (s[32] != s[31])
            return s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        return s[31:0];
    endfunction

    // position of the highest set bit of an axis mask
    function automatic logic [AXW-1:0] top_bit(input logic [AXIS_CELLS_MAX-1:0] m);
        logic [AXW-1:0] r;
        r = '0;
        for (int i = 0; i < AXIS_CELLS_MAX; i++)
            if (m[i])
                r = AXW'(i);
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- design/agcb_front.sv -----
`default_nettype none

module agcb_front #(
    parameter int CELLS_X = 4,
    parameter int CELLS_Y = 4,
    parameter int CELLS_Z = 4
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [31:0]         cfg_data,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [7:0]          object_id,
    input  wire logic [15:0]         instance_id,
    input  wire logic signed [31:0]  box_min_x,
    input  wire logic signed [31:0]  box_min_y,
    input  wire logic signed [31:0]  box_min_z,
    input  wire logic signed [31:0]  box_max_x,
    input  wire logic signed [31:0]  box_max_y,
    input  wire logic signed [31:0]  box_max_z,
    input  wire logic signed [31:0]  offset_x,
    input  wire logic signed [31:0]  offset_y,
    input  wire logic signed [31:0]  offset_z,
    output agcb_pkg::bin_job_t       job,
    output logic                     job_valid,
    input  wire logic                job_ready
);

    localparam int NAX = 3;
    localparam int NC  = agcb_pkg::AXIS_CELLS_MAX;
    localparam int AXIS_CELLS [NAX] = '{CELLS_X, CELLS_Y, CELLS_Z};

    logic signed [31:0] grid_min_reg  [NAX];
    logic [30:0]        cell_size_reg [NAX];
    logic signed [35:0] lo_reg   [NAX][NC];
    logic signed [35:0] hi_reg   [NAX][NC];
    logic signed [35:0] lo_next  [NAX][NC];
    logic signed [35:0] hi_next  [NAX][NC];
    logic signed [31:0] bmin_reg [NAX];
    logic signed [31:0] bmax_reg [NAX];
    logic signed [31:0] in_min   [NAX];
    logic signed [31:0] in_max   [NAX];
    logic signed [31:0] in_off   [NAX];
    logic [7:0]         object_reg;
    logic [15:0]        instance_reg;
    logic               busy_reg;
    logic [NC-1:0]      mask [NAX];

    assign cfg_ready = 1'b1;
    assign in_ready  = !busy_reg;
    assign job_valid = busy_reg;

    assign in_min = '{box_min_x, box_min_y, box_min_z};
    assign in_max = '{box_max_x, box_max_y, box_max_z};
    assign in_off = '{offset_x, offset_y, offset_z};

    // cell bounds from the configuration, one add each
    always_comb
    begin
        for (int a = 0; a < NAX; a++)
        begin
            for (int i = 0; i < NC; i++)
            begin
                lo_next[a][i] = 36'(grid_min_reg[a])
                              + 36'($signed({5'b0, cell_size_reg[a]}) * 36'(i));
                hi_next[a][i] = 36'(grid_min_reg[a])
                              + 36'($signed({5'b0, cell_size_reg[a]}) * 36'(i + 1));
            end
        end
    end

    // inclusive overlap per axis and cell
    always_comb
    begin
        for (int a = 0; a < NAX; a++)
        begin
            for (int i = 0; i < NC; i++)
            begin
                if (i < AXIS_CELLS[a])
                    mask[a][i] = !((36'(bmin_reg[a]) > hi_reg[a][i])
                                || (36'(bmax_reg[a]) < lo_reg[a][i]));
                else
                    mask[a][i] = 1'b0;
            end
        end
    end

    always_comb
    begin
        job.object_id   = object_reg;
        job.instance_id = instance_reg;
        job.mask_x      = mask[agcb_pkg::AXIS_X];
        job.mask_y      = mask[agcb_pkg::AXIS_Y];
        job.mask_z      = mask[agcb_pkg::AXIS_Z];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < NAX; a++)
            begin
                grid_min_reg[a]  <= agcb_pkg::GRID_MIN_RESET;
                cell_size_reg[a] <= agcb_pkg::CELL_SIZE_RESET;
                for (int i = 0; i < NC; i++)
                begin
                    lo_reg[a][i] <= 36'(i) * 36'(agcb_pkg::CELL_SIZE_RESET);
                    hi_reg[a][i] <= 36'(i + 1) * 36'(agcb_pkg::CELL_SIZE_RESET);
                end
            end
            busy_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    agcb_pkg::REG_GRID_MIN_X:  grid_min_reg[agcb_pkg::AXIS_X]  <= cfg_data;
                    agcb_pkg::REG_GRID_MIN_Y:  grid_min_reg[agcb_pkg::AXIS_Y]  <= cfg_data;
                    agcb_pkg::REG_GRID_MIN_Z:  grid_min_reg[agcb_pkg::AXIS_Z]  <= cfg_data;
                    agcb_pkg::REG_CELL_SIZE_X: cell_size_reg[agcb_pkg::AXIS_X] <= cfg_data[30:0];
                    agcb_pkg::REG_CELL_SIZE_Y: cell_size_reg[agcb_pkg::AXIS_Y] <= cfg_data[30:0];
                    agcb_pkg::REG_CELL_SIZE_Z: cell_size_reg[agcb_pkg::AXIS_Z] <= cfg_data[30:0];
                    default: ;
                endcase
            end
            lo_reg <= lo_next;
            hi_reg <= hi_next;
            if (in_valid && in_ready)
                busy_reg <= 1'b1;
            else if (job_valid && job_ready)
                busy_reg <= 1'b0;
        end
    end

    // offset box, saturated per axis
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            object_reg   <= object_id;
            instance_reg <= instance_id;
            for (int a = 0; a < NAX; a++)
            begin
                bmin_reg[a] <= agcb_pkg::sat_add32(in_min[a], in_off[a]);
                bmax_reg[a] <= agcb_pkg::sat_add32(in_max[a], in_off[a]);
            end
        end
    end

endmodule

`default_nettype wire

// ----- design/agcb_queue.sv -----
`default_nettype none

module agcb_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire agcb_pkg::bin_job_t push_job,
    input  wire logic               push_valid,
    output logic                    push_ready,
    output agcb_pkg::bin_job_t      pop_job,
    output logic                    pop_valid,
    input  wire logic               pop_ready
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    agcb_pkg::bin_job_t slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push;
    logic          do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

endmodule

`default_nettype wire

// ----- design/agcb_back.sv -----
`default_nettype none

module agcb_back #(
    parameter int CELLS_X = 4,
    parameter int CELLS_Y = 4,
    parameter int CELLS_Z = 4
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire agcb_pkg::bin_job_t job,
    input  wire logic               job_valid,
    output logic                    job_ready,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [7:0]              echo_object,
    output logic [15:0]             echo_instance,
    output logic [5:0]              cell_index,
    output logic                    hit,
    output logic                    last
);

    localparam int AXW = agcb_pkg::AXW;

    typedef enum logic {
        S_IDLE,
        S_WALK
    } state_t;

    state_t         state_reg;
    logic [AXW-1:0] y_reg;
    logic [AXW-1:0] x_reg;
    logic [AXW-1:0] z_reg;
    logic           out_valid_reg;
    logic [7:0]     object_reg;
    logic [15:0]    instance_reg;
    logic [5:0]     index_reg;
    logic           hit_reg;
    logic           last_reg;

    logic           any_miss;
    logic           hit_cell;
    logic           is_last;
    logic           can_load;
    logic [5:0]     index_now;

    assign out_valid     = out_valid_reg;
    assign echo_object   = object_reg;
    assign echo_instance = instance_reg;
    assign cell_index    = index_reg;
    assign hit           = hit_reg;
    assign last          = last_reg;

    always_comb
    begin
        any_miss  = (job.mask_x == '0) || (job.mask_y == '0) || (job.mask_z == '0);
        hit_cell  = job.mask_y[y_reg] && job.mask_x[x_reg] && job.mask_z[z_reg];
        // last hit is the corner of the highest set bits
        is_last   = (y_reg == agcb_pkg::top_bit(job.mask_y))
                 && (x_reg == agcb_pkg::top_bit(job.mask_x))
                 && (z_reg == agcb_pkg::top_bit(job.mask_z));
        can_load  = !out_valid_reg || out_ready;
        index_now = 6'((int'(y_reg) * CELLS_X + int'(x_reg)) * CELLS_Z + int'(z_reg));
        unique case (state_reg)
            S_IDLE:  job_ready = job_valid && any_miss && can_load;
            S_WALK:  job_ready = hit_cell && is_last && can_load;
            default: job_ready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            y_reg         <= '0;
            x_reg         <= '0;
            z_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (job_valid)
                    begin
                        if (any_miss)
                        begin
                            if (can_load)
                            begin
                                out_valid_reg <= 1'b1;
                                object_reg    <= job.object_id;
                                instance_reg  <= job.instance_id;
                                index_reg     <= '0;
                                hit_reg       <= 1'b0;
                                last_reg      <= 1'b1;
                            end
                        end
                        else
                        begin
                            state_reg <= S_WALK;
                            y_reg     <= '0;
                            x_reg     <= '0;
                            z_reg     <= '0;
                        end
                    end
                end
                S_WALK:
                begin
                    if (!hit_cell || can_load)
                    begin
                        if (hit_cell)
                        begin
                            out_valid_reg <= 1'b1;
                            object_reg    <= job.object_id;
                            instance_reg  <= job.instance_id;
                            index_reg     <= index_now;
                            hit_reg       <= 1'b1;
                            last_reg      <= is_last;
                        end
                        if (hit_cell && is_last)
                            state_reg <= S_IDLE;
                        else if (z_reg == AXW'(CELLS_Z - 1))
                        begin
                            z_reg <= '0;
                            if (x_reg == AXW'(CELLS_X - 1))
                            begin
                                x_reg <= '0;
                                y_reg <= y_reg + 1'b1;
                            end
                            else
                                x_reg <= x_reg + 1'b1;
                        end
                        else
                            z_reg <= z_reg + 1'b1;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- design/aabb_grid_cell_binning_top.sv -----
`default_nettype none

// aabb grid cell binning: takes one instance word (local box, offset, ids), adds the offset
// with saturation and reports every cell of a CELLS_X x CELLS_Y x CELLS_Z grid whose box
// overlaps it, inclusive, in y, x, z order; a box touching no cell gives one miss word
// (hit 0, cell_index 0, last 1). the front takes no new instance while it holds one: the
// offset add is registered, and all cell bounds on each axis are tested on the registered
// box. the back walks the grid one cell per cycle unless a hit cell waits on a stalled
// result, and stops at the last overlapping cell; the cell walk sets the sustained rate.
// a queue of QUEUE_DEPTH instances lets the front keep taking words during a walk, and a
// stalled result holds the back, and the front once the queue is full. configuration
// writes are always ready; a write lands in the configuration registers and the cell bounds
// are registered from them, so no instance should follow a write in the same cycle.

module aabb_grid_cell_binning_top #(
    parameter int CELLS_X     = 4,
    parameter int CELLS_Y     = 4,
    parameter int CELLS_Z     = 4,
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // configuration write channel
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    // instance words in
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [7:0]         object_id,
    input  wire logic [15:0]        instance_id,
    input  wire logic signed [31:0] box_min_x,
    input  wire logic signed [31:0] box_min_y,
    input  wire logic signed [31:0] box_min_z,
    input  wire logic signed [31:0] box_max_x,
    input  wire logic signed [31:0] box_max_y,
    input  wire logic signed [31:0] box_max_z,
    input  wire logic signed [31:0] offset_x,
    input  wire logic signed [31:0] offset_y,
    input  wire logic signed [31:0] offset_z,
    // result words out
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [7:0]              echo_object,
    output logic [15:0]             echo_instance,
    output logic [5:0]              cell_index,
    output logic                    hit,
    output logic                    last
);

    // classified instance from front to queue
    agcb_pkg::bin_job_t push_job;
    logic               push_valid;
    logic               push_ready;
    // head of queue to the cell walk
    agcb_pkg::bin_job_t pop_job;
    logic               pop_valid;
    logic               pop_ready;

    // front: config registers, offset add, per-axis overlap masks
    agcb_front #(
        .CELLS_X (CELLS_X),
        .CELLS_Y (CELLS_Y),
        .CELLS_Z (CELLS_Z)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .object_id   (object_id),
        .instance_id (instance_id),
        .box_min_x   (box_min_x),
        .box_min_y   (box_min_y),
        .box_min_z   (box_min_z),
        .box_max_x   (box_max_x),
        .box_max_y   (box_max_y),
        .box_max_z   (box_max_z),
        .offset_x    (offset_x),
        .offset_y    (offset_y),
        .offset_z    (offset_z),
        .job         (push_job),
        .job_valid   (push_valid),
        .job_ready   (push_ready)
    );

    // short queue decoupling classification from the walk
    agcb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_job   (push_job),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .pop_job    (pop_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready)
    );

    // back: grid walk and registered result word
    agcb_back #(
        .CELLS_X (CELLS_X),
        .CELLS_Y (CELLS_Y),
        .CELLS_Z (CELLS_Z)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .job           (pop_job),
        .job_valid     (pop_valid),
        .job_ready     (pop_ready),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .echo_object   (echo_object),
        .echo_instance (echo_instance),
        .cell_index    (cell_index),
        .hit           (hit),
        .last          (last)
    );

`include "aabb_grid_cell_binning_top_assert.svh"

    // a miss word is always the only and last word, at cell zero
    `AGCB_ASSERT_NOW(a_miss_shape, clk, rst_n, out_valid && !hit, last && (cell_index == 6'd0))
    // front holds a single instance until it is queued
    `AGCB_ASSERT_NEXT(a_front_single, clk, rst_n, in_valid && in_ready, !in_ready)
    // after a push the queue shows a valid head next cycle
    `AGCB_ASSERT_NEXT(a_queue_push, clk, rst_n, push_valid && push_ready, pop_valid)

endmodule

`default_nettype wire
